### hdl/tile_grid_box_collision_check_core_assert.svh
// ----------------------------------------------------------------------------
// Tile grid collision checker: assertion macros
// Shared property forms for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef TILE_GRID_BOX_COLLISION_CHECK_CORE_ASSERT_SVH
`define TILE_GRID_BOX_COLLISION_CHECK_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TGBCC_ASSERT_SAME(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("tgbcc: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define TGBCC_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("tgbcc: next-cycle check failed");

`endif

### hdl/tgbcc_pkg.sv
// ----------------------------------------------------------------------------
// Tile grid collision checker: package
// Constants, payload and control types shared by the block's modules.
// ----------------------------------------------------------------------------
package tgbcc_pkg;

  // Tile store geometry and coordinate format.
  localparam int MAX_COLS  = 64;
  localparam int MAX_ROWS  = 64;
  localparam int FRAC_BITS = 8;
  localparam int COL_W     = $clog2(MAX_COLS);
  localparam int ROW_W     = $clog2(MAX_ROWS);
  localparam int ADDR_W    = ROW_W + COL_W;
  localparam int MEM_DEPTH = MAX_ROWS * MAX_COLS;

  // Field widths.
  localparam int POS_W  = 24;
  localparam int SIZE_W = 16;
  localparam int TS_W   = 8;
  localparam int DIM_W  = 7;

  // Edge numerator is 2*centre +/- size; the non-negative tile index before
  // division by the tile size fits in DIV_W bits.
  localparam int NUM_W = POS_W + 2;
  localparam int DIV_W = POS_W - FRAC_BITS;
  localparam int CNT_W = $clog2(DIV_W);

  // Divider lanes.
  localparam int LANES     = 4;
  localparam int LANE_CMIN = 0;
  localparam int LANE_CMAX = 1;
  localparam int LANE_RMIN = 2;
  localparam int LANE_RMAX = 3;

  // Configuration port.
  localparam int DATA_W    = 32;
  localparam int PADDR_W   = 4;
  localparam int REG_IDX_W = 2;
  localparam logic [REG_IDX_W-1:0] REG_TILE_EDGE   = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_MAP_COLUMNS = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_MAP_ROWS    = 2'd2;

  typedef enum logic [1:0] {
    REQ_WRITE = 2'd0,
    REQ_POINT = 2'd1,
    REQ_STEP  = 2'd2,
    REQ_UNDEF = 2'd3
  } req_kind_t;

  typedef struct packed {
    logic [1:0]              req_type;
    logic [ROW_W-1:0]        tile_row;
    logic [COL_W-1:0]        tile_col;
    logic                    tile_walkable;
    logic signed [POS_W-1:0] pos_a;
    logic signed [POS_W-1:0] pos_b;
    logic signed [POS_W-1:0] step_delta;
    logic                    horizontal;
    logic [SIZE_W-1:0]       box_width;
    logic [SIZE_W-1:0]       box_height;
  } req_t;

  typedef struct packed {
    logic                    is_free;
    logic signed [POS_W-1:0] new_pos;
  } rsp_t;

  typedef struct packed {
    logic [TS_W-1:0]  tile_edge;
    logic [DIM_W-1:0] cols_lim;
    logic [DIM_W-1:0] rows_lim;
  } cfg_t;

  typedef struct packed {
    logic             neg;
    logic [DIV_W-1:0] quo;
    logic [TS_W-1:0]  rem;
  } lane_t;

  typedef struct packed {
    logic load;
    logic calc_want;
    logic mem_we;
    logic lanes_load;
    logic div_step;
    logic walk_init;
    logic rd_req;
    logic walk_next;
    logic fin;
    logic fin_free;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic       ts_zero;
    logic       off_grid;
    logic       tile_bit;
    logic       walk_last;
  } dp_stat_t;

endpackage

### hdl/tgbcc_regs.sv
// ----------------------------------------------------------------------------
// Tile grid collision checker: configuration registers
// APB-style register file holding tile size and grid dimensions.
// ----------------------------------------------------------------------------
module tgbcc_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tgbcc_pkg::PADDR_W-1:0] paddr,
  input  logic [tgbcc_pkg::DATA_W-1:0]  pwdata,
  output logic [tgbcc_pkg::DATA_W-1:0]  prdata,
  output logic                          pready,
  output tgbcc_pkg::cfg_t               cfg
);
  import tgbcc_pkg::*;

  logic [TS_W-1:0]      tile_edge_r, tile_edge_nxt;
  logic [DIM_W-1:0]     map_columns_r, map_columns_nxt;
  logic [DIM_W-1:0]     map_rows_r, map_rows_nxt;
  logic                 wr_en;
  logic [REG_IDX_W-1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[PADDR_W-1:2];

  always_comb begin
    tile_edge_nxt   = tile_edge_r;
    map_columns_nxt = map_columns_r;
    map_rows_nxt    = map_rows_r;
    if (wr_en) begin
      case (reg_idx)
        REG_TILE_EDGE:   tile_edge_nxt   = pwdata[TS_W-1:0];
        REG_MAP_COLUMNS: map_columns_nxt = pwdata[DIM_W-1:0];
        REG_MAP_ROWS:    map_rows_nxt    = pwdata[DIM_W-1:0];
        default:         ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tile_edge_r   <= '0;
      map_columns_r <= '0;
      map_rows_r    <= '0;
    end else begin
      tile_edge_r   <= tile_edge_nxt;
      map_columns_r <= map_columns_nxt;
      map_rows_r    <= map_rows_nxt;
    end
  end

  always_comb begin
    case (reg_idx)
      REG_TILE_EDGE:   prdata = DATA_W'(tile_edge_r);
      REG_MAP_COLUMNS: prdata = DATA_W'(map_columns_r);
      REG_MAP_ROWS:    prdata = DATA_W'(map_rows_r);
      default:         prdata = '0;
    endcase
  end

  // Dimensions beyond the store are clipped to the store.
  assign cfg.tile_edge = tile_edge_r;
  assign cfg.cols_lim  = (map_columns_r > DIM_W'(MAX_COLS)) ? DIM_W'(MAX_COLS) : map_columns_r;
  assign cfg.rows_lim  = (map_rows_r > DIM_W'(MAX_ROWS)) ? DIM_W'(MAX_ROWS) : map_rows_r;

endmodule

### hdl/tgbcc_ctrl.sv
// ----------------------------------------------------------------------------
// Tile grid collision checker: controller
// Sequences decode, division, bounds check and tile walk for one transaction.
// ----------------------------------------------------------------------------
module tgbcc_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  tgbcc_pkg::dp_stat_t  stat,
  output tgbcc_pkg::dp_cmd_t   cmd,
  output logic                 out_strobe
);
  import tgbcc_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_DECODE = 7'b0000010,
    S_EDGE   = 7'b0000100,
    S_DIV    = 7'b0001000,
    S_CHECK  = 7'b0010000,
    S_RD     = 7'b0100000,
    S_EV     = 7'b1000000
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             strobe_r;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.calc_want = 1'b1;
        case (req_kind_t'(stat.req_type))
          REQ_WRITE: begin
            cmd.mem_we = 1'b1;
            cmd.fin    = 1'b1;
            state_nxt  = S_IDLE;
          end
          REQ_POINT, REQ_STEP: state_nxt = S_EDGE;
          default: begin
            cmd.fin   = 1'b1;
            state_nxt = S_IDLE;
          end
        endcase
      end
      S_EDGE: begin
        if (stat.ts_zero) begin
          cmd.fin      = 1'b1;
          cmd.fin_free = 1'b1;
          state_nxt    = S_IDLE;
        end else begin
          cmd.lanes_load = 1'b1;
          cnt_nxt        = '0;
          state_nxt      = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DIV_W - 1)) begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.off_grid) begin
          cmd.fin   = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          cmd.walk_init = 1'b1;
          state_nxt     = S_RD;
        end
      end
      S_RD: begin
        cmd.rd_req = 1'b1;
        state_nxt  = S_EV;
      end
      S_EV: begin
        if (!stat.tile_bit) begin
          cmd.fin   = 1'b1;
          state_nxt = S_IDLE;
        end else if (stat.walk_last) begin
          cmd.fin      = 1'b1;
          cmd.fin_free = 1'b1;
          state_nxt    = S_IDLE;
        end else begin
          cmd.walk_next = 1'b1;
          state_nxt     = S_RD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      cnt_r    <= '0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      strobe_r <= cmd.fin;
    end
  end

  assign busy       = (state_r != S_IDLE);
  assign out_strobe = strobe_r;

endmodule

### hdl/tgbcc_dp.sv
// ----------------------------------------------------------------------------
// Tile grid collision checker: datapath
// Request register, step saturation, four restoring divider lanes, tile walk
// counters, tile store and result register.
// ----------------------------------------------------------------------------
module tgbcc_dp (
  input  logic                clk,
  input  tgbcc_pkg::req_t     in_data,
  input  tgbcc_pkg::cfg_t     cfg,
  input  tgbcc_pkg::dp_cmd_t  cmd,
  output tgbcc_pkg::dp_stat_t stat,
  output tgbcc_pkg::rsp_t     out_data
);
  import tgbcc_pkg::*;

  // Edge index before division: floor((2*centre +/- size) / 2^(FRAC_BITS+1)).
  function automatic lane_t edge_init(input logic [POS_W-1:0] cen,
                                      input logic [SIZE_W-1:0] size,
                                      input logic plus);
    logic [NUM_W-1:0] twice;
    logic [NUM_W-1:0] ext;
    logic [NUM_W-1:0] num;
    lane_t            l;
    twice = {cen[POS_W-1], cen, 1'b0};
    ext   = {{(NUM_W-SIZE_W){1'b0}}, size};
    num   = plus ? (twice + ext) : (twice - ext);
    l.neg = num[NUM_W-1];
    l.quo = num[FRAC_BITS+1 +: DIV_W];
    l.rem = '0;
    return l;
  endfunction

  // Point coordinate truncated toward zero to whole pixels, as a magnitude.
  function automatic lane_t point_init(input logic [POS_W-1:0] v);
    logic [POS_W-1:0] mag;
    lane_t            l;
    mag   = v[POS_W-1] ? (~v + 1'b1) : v;
    l.neg = v[POS_W-1];
    l.quo = mag[FRAC_BITS +: DIV_W];
    l.rem = '0;
    return l;
  endfunction

  req_t                    req_r;
  logic signed [POS_W-1:0] want_r, want_nxt;
  lane_t                   lane_r [LANES];
  lane_t                   lane_nxt [LANES];
  logic [ROW_W-1:0]        row_r, row_nxt;
  logic [COL_W-1:0]        col_r, col_nxt;
  logic                    rd_bit_r;
  rsp_t                    out_r;
  logic                    tile_mem [MEM_DEPTH];

  logic                    is_step;
  logic [POS_W:0]          sum;
  logic [POS_W-1:0]        cen_x;
  logic [POS_W-1:0]        cen_y;
  logic [LANES-1:0]        lane_off;
  logic [COL_W-1:0]        cmin_c, cmax_c;
  logic [ROW_W-1:0]        rmin_r, rmax_r;

  assign is_step = (req_kind_t'(req_r.req_type) == REQ_STEP);

  // Saturating step sum.
  assign sum = {req_r.pos_a[POS_W-1], req_r.pos_a}
             + {req_r.step_delta[POS_W-1], req_r.step_delta};

  always_comb begin
    want_nxt = want_r;
    if (cmd.calc_want) begin
      if (sum[POS_W] != sum[POS_W-1]) begin
        want_nxt = sum[POS_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
      end else begin
        want_nxt = sum[POS_W-1:0];
      end
    end
  end

  assign cen_x = req_r.horizontal ? want_r : req_r.pos_b;
  assign cen_y = req_r.horizontal ? req_r.pos_b : want_r;

  // Divider lanes: one quotient bit per step, all four lanes together.
  always_comb begin
    logic [TS_W:0] trial;
    logic          ge;
    trial = '0;
    ge    = 1'b0;
    for (int i = 0; i < LANES; i++) begin
      lane_nxt[i] = lane_r[i];
    end
    if (cmd.lanes_load) begin
      if (is_step) begin
        lane_nxt[LANE_CMIN] = edge_init(cen_x, req_r.box_width, 1'b0);
        lane_nxt[LANE_CMAX] = edge_init(cen_x, req_r.box_width, 1'b1);
        lane_nxt[LANE_RMIN] = edge_init(cen_y, req_r.box_height, 1'b0);
        lane_nxt[LANE_RMAX] = edge_init(cen_y, req_r.box_height, 1'b1);
      end else begin
        lane_nxt[LANE_CMIN] = point_init(req_r.pos_a);
        lane_nxt[LANE_CMAX] = point_init(req_r.pos_a);
        lane_nxt[LANE_RMIN] = point_init(req_r.pos_b);
        lane_nxt[LANE_RMAX] = point_init(req_r.pos_b);
      end
    end else if (cmd.div_step) begin
      for (int i = 0; i < LANES; i++) begin
        trial           = {lane_r[i].rem, lane_r[i].quo[DIV_W-1]};
        ge              = (trial >= {1'b0, cfg.tile_edge});
        lane_nxt[i].rem = ge ? TS_W'(trial - {1'b0, cfg.tile_edge}) : trial[TS_W-1:0];
        lane_nxt[i].quo = {lane_r[i].quo[DIV_W-2:0], ge};
      end
    end
  end

  // A negative box edge is always off the grid; a negative point coordinate
  // only when its truncated tile index is not zero.
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      lane_off[i] = lane_r[i].neg & (is_step | (lane_r[i].quo != '0));
    end
  end

  assign cmin_c = lane_r[LANE_CMIN].quo[COL_W-1:0];
  assign cmax_c = lane_r[LANE_CMAX].quo[COL_W-1:0];
  assign rmin_r = lane_r[LANE_RMIN].quo[ROW_W-1:0];
  assign rmax_r = lane_r[LANE_RMAX].quo[ROW_W-1:0];

  always_comb begin
    row_nxt = row_r;
    col_nxt = col_r;
    if (cmd.walk_init) begin
      row_nxt = rmin_r;
      col_nxt = cmin_c;
    end else if (cmd.walk_next) begin
      if (col_r == cmax_c) begin
        col_nxt = cmin_c;
        row_nxt = row_r + 1'b1;
      end else begin
        col_nxt = col_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= in_data;
    end
    want_r <= want_nxt;
    for (int i = 0; i < LANES; i++) begin
      lane_r[i] <= lane_nxt[i];
    end
    row_r <= row_nxt;
    col_r <= col_nxt;
    if (cmd.fin) begin
      out_r.is_free <= cmd.fin_free;
      if (is_step) begin
        out_r.new_pos <= cmd.fin_free ? want_r : req_r.pos_a;
      end else begin
        out_r.new_pos <= '0;
      end
    end
  end

  // Tile store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.mem_we) begin
      tile_mem[{req_r.tile_row, req_r.tile_col}] <= req_r.tile_walkable;
    end
    if (cmd.rd_req) begin
      rd_bit_r <= tile_mem[{row_r, col_r}];
    end
  end

  assign stat.req_type  = req_r.req_type;
  assign stat.ts_zero   = (cfg.tile_edge == '0);
  assign stat.off_grid  = (|lane_off)
                        | (lane_r[LANE_CMAX].quo >= DIV_W'(cfg.cols_lim))
                        | (lane_r[LANE_RMAX].quo >= DIV_W'(cfg.rows_lim));
  assign stat.tile_bit  = rd_bit_r;
  assign stat.walk_last = (row_r == rmax_r) && (col_r == cmax_c);

  assign out_data = out_r;

endmodule

### hdl/tile_grid_box_collision_check_core.sv
// ----------------------------------------------------------------------------
// Tile grid collision checker: top level
// Occupancy grid with point and axis-aligned box step queries.
// ----------------------------------------------------------------------------
// A transaction is accepted on a rising edge where start is high and busy is
// low; the block then handles one transaction at a time and raises
// out_strobe for exactly one cycle with the result, which the receiver cannot
// hold off. A tile write or an undefined request type finishes in the decode
// state, and a query with a tile size of zero in the edge state. Any other
// query runs a 16-step restoring divider (one quotient bit per cycle, four
// lanes at once, on both box edges in both axes for a step query) followed
// by a walk over the overlapped tiles, each read in a read state and checked
// in an evaluate state, through a tile store with one write port and one
// registered read port. A query whose box reaches off the grid reads no
// tiles; a box covering R rows and C columns reads at most R*C tiles. The
// tile store has no reset: a tile must be written before any query reads it.
// Configuration registers (tile size at byte address 0, columns at 4, rows at
// 8) must only be written while the block is idle.
module tile_grid_box_collision_check_core (
  input  logic                                    clk,
  input  logic                                    rst_n,
  // Request channel.
  input  logic                                    start,
  output logic                                    busy,
  input  tgbcc_pkg::req_t                         in_data,
  // Result channel.
  output logic                                    out_strobe,
  output tgbcc_pkg::rsp_t                         out_data,
  // Configuration port.
  input  logic                                    psel,
  input  logic                                    penable,
  input  logic                                    pwrite,
  input  logic [tgbcc_pkg::PADDR_W-1:0]           paddr,
  input  logic [tgbcc_pkg::DATA_W-1:0]            pwdata,
  output logic [tgbcc_pkg::DATA_W-1:0]            prdata,
  output logic                                    pready
);
  import tgbcc_pkg::*;

  cfg_t     cfg;
  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Register file: tile size and the grid dimensions, clipped to the store.
  tgbcc_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Controller: owns the handshake and the sequence of each transaction.
  tgbcc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .stat       (stat),
    .cmd        (cmd),
    .out_strobe (out_strobe)
  );

  // Datapath: arithmetic, tile store and the registered result.
  tgbcc_dp u_dp (
    .clk      (clk),
    .in_data  (in_data),
    .cfg      (cfg),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (out_data)
  );

endmodule

### hdl/tgbcc_checker.sv
// ----------------------------------------------------------------------------
// Tile grid collision checker: port checker
// Port-level properties of the handshake, bound to the top level.
// ----------------------------------------------------------------------------
`include "tile_grid_box_collision_check_core_assert.svh"

module tgbcc_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_strobe
);

  // An accepted transaction always makes the block busy in the cycle after.
  `TGBCC_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy)

  // A result is shown only once the block has returned to idle.
  `TGBCC_ASSERT_SAME(a_strobe_idle, clk, rst_n, out_strobe, !busy)

  // One transaction gives one result: the strobe is a pulse that is never held high.
  `TGBCC_ASSERT_NEXT(a_strobe_single, clk, rst_n, out_strobe, !out_strobe)

  // No result appears without a transaction in flight.
  `TGBCC_ASSERT_NEXT(a_no_spurious, clk, rst_n, !busy && !out_strobe, !out_strobe)

endmodule

bind tile_grid_box_collision_check_core tgbcc_checker u_tgbcc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .out_strobe (out_strobe)
);

### tb/sv/tile_grid_box_collision_check_core_tb.sv
// ----------------------------------------------------------------------------
// Tile grid collision checker: self-checking testbench
// Loads walkable tiles, fires point and box step queries at several register
// settings and compares every result with an in-bench prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tile_grid_box_collision_check_core_tb;
  import tgbcc_pkg::*;

  // Run control. The slowest query we ever generate reads 64 tiles, so the
  // limit leaves a wide margin over the N_PHASES * PHASE_ITEMS random and the
  // directed transactions at the heaviest sender gaps.
  localparam int     CYCLE_LIMIT = 2_000_000;
  localparam int     TAIL_CYCLES = 200;
  localparam int     MAX_AREA    = 64;
  localparam int     PHASE_ITEMS = 190;
  localparam int     N_PHASES    = 9;
  localparam longint ONE_PX      = longint'(1) << FRAC_BITS;
  localparam longint POS_MAX     = (longint'(1) << (POS_W - 1)) - 1;
  localparam longint POS_MIN     = -(longint'(1) << (POS_W - 1));

  // Register settings of the random phases: extremes of every register are in
  // here, including a grid wider than the store and an empty grid.
  localparam int PH_TS   [N_PHASES] = '{1, 255, 7, 3, 32, 255, 10, 16, 0};
  localparam int PH_COLS [N_PHASES] = '{64, 64, 127, 1, 0, 1, 64, 20, 64};
  localparam int PH_ROWS [N_PHASES] = '{64, 64, 127, 1, 0, 127, 5, 20, 64};

  // A pending transaction; hold makes the sender wait until every result
  // already owed by the block has come back.
  typedef struct packed {
    logic hold;
    req_t req;
  } job_t;

  logic                   clk     = 1'b0;
  logic                   rst_n   = 1'b0;
  logic                   start   = 1'b0;
  logic                   busy;
  req_t                   in_data = '0;
  logic                   out_strobe;
  rsp_t                   out_data;
  logic                   psel    = 1'b0;
  logic                   penable = 1'b0;
  logic                   pwrite  = 1'b0;
  logic [PADDR_W-1:0]     paddr   = '0;
  logic [DATA_W-1:0]      pwdata  = '0;
  logic [DATA_W-1:0]      prdata;
  logic                   pready;

  // Register copies as the block should hold them.
  logic [TS_W-1:0]        tile_edge_r = '0;
  logic [DIM_W-1:0]       cols_r      = '0;
  logic [DIM_W-1:0]       rows_r      = '0;

  // grid_bits mirrors the tile store at the point of acceptance; grid_loaded
  // records, at generation time, which tiles have a write queued ahead.
  bit                     grid_bits   [MAX_ROWS*MAX_COLS];
  bit                     grid_loaded [MAX_ROWS*MAX_COLS];

  job_t                   req_backlog[$];
  rsp_t                   awaited_outcomes[$];
  int                     n_queued = 0;
  int                     n_sent   = 0;
  int                     n_done   = 0;
  int                     gap_pct  = 0;
  int                     err_cnt  = 0;
  int                     cycle_cnt = 0;

  tile_grid_box_collision_check_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_strobe(out_strobe),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // Collision arithmetic
  // --------------------------------------------------------------------------

  // The register value saturates at the store size.
  function automatic longint grid_cols();
    return (cols_r > MAX_COLS) ? longint'(MAX_COLS) : longint'(cols_r);
  endfunction

  function automatic longint grid_rows();
    return (rows_r > MAX_ROWS) ? longint'(MAX_ROWS) : longint'(rows_r);
  endfunction

  // Division rounding toward minus infinity, as used for the box edges.
  function automatic longint floor_quot(longint num, longint den);
    longint q = num / den;
    if ((num % den) != 0 && num < 0) q--;
    return q;
  endfunction

  // Position the step aims for, saturated to the 24-bit signed range.
  function automatic longint step_target(req_t r);
    longint sum = longint'($signed(r.pos_a)) + longint'($signed(r.step_delta));
    if (sum > POS_MAX) sum = POS_MAX;
    if (sum < POS_MIN) sum = POS_MIN;
    return sum;
  endfunction

  // Tile rectangle a query touches. Returns 1 only when the whole rectangle
  // lies on the grid, which is exactly when the block has to read tiles.
  function automatic bit tile_span(input req_t r, output longint r0, output longint r1,
                                   output longint c0, output longint c1);
    longint ts, den, want, cx, cy, w, h;
    ts = longint'(tile_edge_r);
    r0 = 0;
    r1 = 0;
    c0 = 0;
    c1 = 0;
    if (ts == 0) return 1'b0;
    if (r.req_type == REQ_POINT) begin
      // Whole pixels first (truncated toward zero), then whole tiles.
      c0 = (longint'($signed(r.pos_a)) / ONE_PX) / ts;
      r0 = (longint'($signed(r.pos_b)) / ONE_PX) / ts;
      c1 = c0;
      r1 = r0;
    end else if (r.req_type == REQ_STEP) begin
      want = step_target(r);
      cx   = r.horizontal ? want : longint'($signed(r.pos_b));
      cy   = r.horizontal ? longint'($signed(r.pos_b)) : want;
      w    = longint'(r.box_width);
      h    = longint'(r.box_height);
      // Edges are centre -/+ half the size; doubling everything keeps the
      // half-LSB exact.
      den  = ts << (FRAC_BITS + 1);
      c0   = floor_quot(2 * cx - w, den);
      c1   = floor_quot(2 * cx + w, den);
      r0   = floor_quot(2 * cy - h, den);
      r1   = floor_quot(2 * cy + h, den);
    end else begin
      return 1'b0;
    end
    return (r0 >= 0 && c0 >= 0 && r1 < grid_rows() && c1 < grid_cols());
  endfunction

  // Result the block owes for one accepted transaction; tile writes also
  // update the store copy.
  function automatic rsp_t collision_outcome(req_t r);
    rsp_t   res;
    longint r0, r1, c0, c1, want;
    bit     clear;
    int     rr, cc;
    res = '0;
    if (r.req_type == REQ_WRITE) begin
      grid_bits[int'(r.tile_row) * MAX_COLS + int'(r.tile_col)] = r.tile_walkable;
    end else if (r.req_type == REQ_POINT || r.req_type == REQ_STEP) begin
      clear = tile_span(r, r0, r1, c0, c1);
      if (tile_edge_r == 0) begin
        clear = 1'b1;
      end else if (clear) begin
        for (rr = int'(r0); rr <= int'(r1); rr++)
          for (cc = int'(c0); cc <= int'(c1); cc++)
            if (!grid_bits[rr * MAX_COLS + cc]) clear = 1'b0;
      end
      res.is_free = clear;
      if (r.req_type == REQ_STEP) begin
        want        = step_target(r);
        res.new_pos = clear ? want[POS_W-1:0] : r.pos_a;
      end
    end
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Transaction generation
  // --------------------------------------------------------------------------

  // Every field random; callers then shape the fields that matter.
  function automatic req_t rand_req();
    logic [127:0] raw;
    raw = {$urandom(), $urandom(), $urandom(), $urandom()};
    return raw[$bits(req_t)-1:0];
  endfunction

  // Mostly on or just around the grid, sometimes slightly negative (to hit
  // truncation toward zero) and sometimes anywhere in the 24-bit range.
  function automatic logic [POS_W-1:0] rand_coord(longint ext, longint pad);
    longint v;
    case ($urandom_range(0, 9))
      0:       v = longint'($urandom());
      1:       v = -longint'($urandom_range(0, 1024));
      default: v = longint'($urandom_range(0, int'(ext + pad))) - pad / 2;
    endcase
    return v[POS_W-1:0];
  endfunction

  function automatic req_t mk_point(longint x, longint y);
    req_t r = rand_req();
    r.req_type = REQ_POINT;
    r.pos_a    = x[POS_W-1:0];
    r.pos_b    = y[POS_W-1:0];
    return r;
  endfunction

  function automatic req_t mk_step(longint a, longint b, longint d, bit horiz,
                                   longint w, longint h);
    req_t r = rand_req();
    r.req_type   = REQ_STEP;
    r.pos_a      = a[POS_W-1:0];
    r.pos_b      = b[POS_W-1:0];
    r.step_delta = d[POS_W-1:0];
    r.horizontal = horiz;
    r.box_width  = w[SIZE_W-1:0];
    r.box_height = h[SIZE_W-1:0];
    return r;
  endfunction

  task automatic queue_tile_write(input int row, input int col, input bit walk);
    req_t r = rand_req();
    r.req_type      = REQ_WRITE;
    r.tile_row      = row[ROW_W-1:0];
    r.tile_col      = col[COL_W-1:0];
    r.tile_walkable = walk;
    grid_loaded[row * MAX_COLS + col] = 1'b1;
    req_backlog.push_back({1'b0, r});
    n_queued++;
  endtask

  // The tile store has no reset, so any tile a query would read gets a write
  // queued ahead of it; those tiles are mostly walkable so that the box walk
  // gets past its first tile.
  task automatic queue_query(input req_t r, input bit hold);
    longint r0, r1, c0, c1;
    int     rr, cc;
    if (tile_span(r, r0, r1, c0, c1)) begin
      for (rr = int'(r0); rr <= int'(r1); rr++)
        for (cc = int'(c0); cc <= int'(c1); cc++)
          if (!grid_loaded[rr * MAX_COLS + cc])
            queue_tile_write(rr, cc, $urandom_range(0, 9) != 0);
    end
    req_backlog.push_back({hold, r});
    n_queued++;
  endtask

  task automatic queue_random_item();
    req_t   r;
    longint pad, x_ext, y_ext, want, d, r0, r1, c0, c1;
    int     pick, size_cap;
    r     = rand_req();
    pad   = longint'(tile_edge_r) << FRAC_BITS;
    x_ext = grid_cols() * pad;
    y_ext = grid_rows() * pad;
    pick  = $urandom_range(0, 99);
    if (pick < 6) begin
      // Stray write anywhere in the store, often making a tile a wall.
      queue_tile_write($urandom_range(0, MAX_ROWS - 1), $urandom_range(0, MAX_COLS - 1),
                       1'($urandom_range(0, 1)));
    end else if (pick < 10) begin
      r.req_type = REQ_UNDEF;
      queue_query(r, 1'b0);
    end else if (pick < 50) begin
      r.req_type = REQ_POINT;
      r.pos_a    = rand_coord(x_ext, pad);
      r.pos_b    = rand_coord(y_ext, pad);
      queue_query(r, $urandom_range(0, 79) == 0);
    end else begin
      r.req_type = REQ_STEP;
      want       = longint'($signed(rand_coord(r.horizontal ? x_ext : y_ext, pad)));
      r.pos_b    = rand_coord(r.horizontal ? y_ext : x_ext, pad);
      // Mostly a step of up to a tile either way; now and then any delta,
      // which brings in saturation.
      if ($urandom_range(0, 9) == 0) d = longint'($signed(r.step_delta));
      else d = longint'($urandom_range(0, int'(2 * pad))) - pad;
      r.step_delta = d[POS_W-1:0];
      want         = want - d;
      r.pos_a      = want[POS_W-1:0];
      if ($urandom_range(0, 9) != 0) begin
        size_cap     = (2 * pad > 65535) ? 65535 : int'(2 * pad);
        r.box_width  = SIZE_W'($urandom_range(0, size_cap));
        r.box_height = SIZE_W'($urandom_range(0, size_cap));
      end
      // Keep the walk short: a box of at most half a tile spans at most two tiles each way.
      if (tile_span(r, r0, r1, c0, c1) && (r1 - r0 + 1) * (c1 - c0 + 1) > MAX_AREA) begin
        r.box_width  = SIZE_W'($urandom_range(0, int'(pad / 2)));
        r.box_height = SIZE_W'($urandom_range(0, int'(pad / 2)));
      end
      queue_query(r, $urandom_range(0, 79) == 0);
    end
  endtask

  // --------------------------------------------------------------------------
  // Register access
  // --------------------------------------------------------------------------

  // Block idle: nothing left to send, every result back, busy low.
  task automatic wait_quiet();
    do @(negedge clk);
    while (req_backlog.size() != 0 || start || n_sent != n_done || busy);
  endtask

  task automatic reg_write(input logic [REG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Read back in the access cycle, sampled mid-cycle so that it is settled.
  task automatic reg_read(input logic [REG_IDX_W-1:0] idx, input logic [DATA_W-1:0] want);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    if (prdata !== want) begin
      $error("register %0d readback mismatch: expected %0d, got %0d", idx, want, prdata);
      err_cnt++;
    end
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic apply_config(input int ts, input int cols, input int rows);
    wait_quiet();
    reg_write(REG_TILE_EDGE, ts);
    tile_edge_r = ts[TS_W-1:0];
    reg_write(REG_MAP_COLUMNS, cols);
    cols_r = cols[DIM_W-1:0];
    reg_write(REG_MAP_ROWS, rows);
    rows_r = rows[DIM_W-1:0];
    reg_read(REG_TILE_EDGE, ts);
    reg_read(REG_MAP_COLUMNS, cols);
    reg_read(REG_MAP_ROWS, rows);
  endtask

  // --------------------------------------------------------------------------
  // Sender: presents the backlog with random gaps. The expected result is
  // worked out at the edge that accepts the transaction, so tile writes and
  // queries are seen in exactly the order the block sees them. start is
  // assigned once per edge, so back-to-back transactions keep it high.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : drive_req
    job_t nxt;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        awaited_outcomes.push_back(collision_outcome(in_data));
        n_sent++;
      end
      if (!start || !busy) begin
        if (req_backlog.size() != 0 && $urandom_range(0, 99) >= gap_pct &&
            !(req_backlog[0].hold && n_sent != n_done)) begin
          nxt = req_backlog.pop_front();
          in_data <= nxt.req;
          start   <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result checker. The strobe lasts one cycle and cannot be held off, so
  // every strobed cycle is one result. n_done is updated with a nonblocking
  // assignment so that the sender's hold logic sees a stable count.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : check_rsp
    rsp_t want;
    if (rst_n && out_strobe) begin
      if (awaited_outcomes.size() == 0) begin
        $error("result with none outstanding: is_free=%0d new_pos=%0d",
               out_data.is_free, $signed(out_data.new_pos));
        err_cnt++;
      end else begin
        want = awaited_outcomes.pop_front();
        if (out_data.is_free !== want.is_free) begin
          $error("is_free mismatch: expected %0d, got %0d", want.is_free, out_data.is_free);
          err_cnt++;
        end
        if (out_data.new_pos !== want.new_pos) begin
          $error("new_pos mismatch: expected %0d, got %0d",
                 $signed(want.new_pos), $signed(out_data.new_pos));
          err_cnt++;
        end
        n_done <= n_done + 1;
      end
    end
  end

  // Watchdog: a hang anywhere ends the run as a failure.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus sequence
  // --------------------------------------------------------------------------
  initial begin
    req_t odd;
    int   rr, cc, p, goal;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    gap_pct = 23;

    // Registers still at reset: a tile size of zero frees everything, and
    // the step target saturates at both ends of the range.
    queue_query(mk_point(POS_MAX, POS_MIN), 1'b0);
    queue_query(mk_step(POS_MAX, 0, POS_MAX, 1'b1, 16'hFFFF, 16'hFFFF), 1'b0);
    queue_query(mk_step(POS_MIN, POS_MAX, POS_MIN, 1'b0, 0, 0), 1'b0);
    odd          = rand_req();
    odd.req_type = REQ_UNDEF;
    queue_query(odd, 1'b0);

    // Small 3 x 2 grid of 16-pixel tiles, all walkable but row 1 column 1.
    apply_config(16, 3, 2);
    for (rr = 0; rr < 2; rr++)
      for (cc = 0; cc < 3; cc++)
        queue_tile_write(rr, cc, !(rr == 1 && cc == 1));
    queue_tile_write(MAX_ROWS - 1, MAX_COLS - 1, 1'b1);

    queue_query(mk_point(8 * ONE_PX, 8 * ONE_PX), 1'b0);
    queue_query(mk_point(24 * ONE_PX, 24 * ONE_PX), 1'b0);
    // Half a pixel left of the origin truncates into column zero.
    queue_query(mk_point(-ONE_PX / 2, 0), 1'b0);
    queue_query(mk_point(48 * ONE_PX, 8 * ONE_PX), 1'b0);
    queue_query(mk_point(-16 * ONE_PX, 8 * ONE_PX), 1'b0);
    queue_query(mk_step(8 * ONE_PX, 8 * ONE_PX, 8 * ONE_PX, 1'b1, 8 * ONE_PX, 8 * ONE_PX),
                1'b0);
    queue_query(mk_step(8 * ONE_PX, 24 * ONE_PX, 16 * ONE_PX, 1'b0, 4 * ONE_PX, 4 * ONE_PX),
                1'b0);
    // A box one LSB wide centred on the origin pokes half an LSB off the grid.
    queue_query(mk_step(0, 8 * ONE_PX, 0, 1'b1, 1, 2 * ONE_PX), 1'b0);
    queue_query(mk_step(0, 8 * ONE_PX, 0, 1'b1, 0, 0), 1'b0);
    queue_query(mk_step(44 * ONE_PX, 8 * ONE_PX, 3 * ONE_PX, 1'b1, 4 * ONE_PX, 4 * ONE_PX),
                1'b0);
    queue_query(mk_step(POS_MAX, 8 * ONE_PX, 1, 1'b1, 4 * ONE_PX, 4 * ONE_PX), 1'b0);

    // Random phases: the sender idles sometimes, then often, then never.
    for (p = 0; p < N_PHASES; p++) begin
      apply_config(PH_TS[p], PH_COLS[p], PH_ROWS[p]);
      gap_pct = (p < 3) ? 23 : (p < 6) ? 81 : 0;
      goal    = n_queued + PHASE_ITEMS;
      while (n_queued < goal) queue_random_item();
    end

    wait_quiet();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (awaited_outcomes.size() != 0) begin
      $error("%0d results never arrived", awaited_outcomes.size());
      err_cnt++;
    end
    if (err_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
